>>> hdl/assert_macros.svh
// Assertion macros used by the tachometer core module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define ASSERT_CLOCKED(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hdl/ept_pkg.sv
// Types, constants and codes shared by the encoder pulse tachometer modules.
package ept_pkg;

   localparam int COUNT_BITS     = 16;
   localparam int POSITION_BITS  = 32;
   localparam int POS_OUT_BITS   = 32;
   localparam int SPEED_BITS     = 16;
   localparam int WINDOW_BITS    = 8;
   localparam int DIR_BITS       = 2;

   localparam int TENTHS         = 10;
   localparam int PULSES_PER_REV = 14;
   localparam int SCALE_NUM      = TENTHS / 2;
   localparam int SCALE_DEN      = PULSES_PER_REV / 2;

   localparam int X_BITS         = COUNT_BITS + 3;
   localparam int RECIP_SHIFT    = COUNT_BITS + 6;
   localparam int RECIP_BITS     = RECIP_SHIFT - 1;
   localparam int PROD_BITS      = X_BITS + RECIP_BITS;
   localparam int SAT_BITS       = COUNT_BITS + SPEED_BITS;
   localparam logic [RECIP_BITS-1:0] RECIP =
      RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'(SCALE_DEN - 1)) / 64'(SCALE_DEN));
   localparam logic [SPEED_BITS-1:0] SPEED_MAX = '1;

   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 8'd9;
   localparam logic [0:0] REG_WINDOW = 1'b0;

   localparam int REQ_TDATA_BITS = 8;
   localparam int REQ_TUSER_BITS = 2;
   localparam int RSP_TDATA_BITS = 56;

   typedef enum logic [1:0] {
      CMD_PULSE_A = 2'd0,
      CMD_PULSE_B = 2'd1,
      CMD_TICK    = 2'd2,
      CMD_SET_DIR = 2'd3
   } command_type;

   typedef enum logic [DIR_BITS-1:0] {
      DIR_UNDEF = 2'd0,
      DIR_RIGHT = 2'd1,
      DIR_LEFT  = 2'd2
   } direction_type;

   typedef struct packed {
      logic [POS_OUT_BITS-1:0] position_tenths;
      logic [SPEED_BITS-1:0]   speed_tenths;
      logic [DIR_BITS-1:0]     direction_now;
      logic                    watchdog_level;
   } result_type;

endpackage

>>> hdl/ept_csr.sv
// Configuration register bank holding the window length.
module ept_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ept_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [ept_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [ept_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready,
   output logic [ept_pkg::WINDOW_BITS-1:0]     window_ticks_minus_one
);

   logic [ept_pkg::WINDOW_BITS-1:0] window_ff;
   logic [ept_pkg::WINDOW_BITS-1:0] window_in;
   logic                            hit;

   assign hit        = (csr_paddr[ept_pkg::CSR_ADDR_BITS-1] == ept_pkg::REG_WINDOW);
   assign csr_pready = 1'b1;

   always_comb begin
      window_in = window_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         window_in = csr_pwdata[ept_pkg::WINDOW_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= ept_pkg::WINDOW_RESET;
      end else begin
         window_ff <= window_in;
      end
   end

   assign csr_prdata = hit ? ept_pkg::CSR_DATA_BITS'(window_ff) : '0;
   assign window_ticks_minus_one = window_ff;

endmodule

>>> hdl/ept_speed.sv
// Speed calculation: larger pulse count scaled to tenths of a turn, saturated.
module ept_speed (
   input  logic [ept_pkg::COUNT_BITS-1:0] pulses_a,
   input  logic [ept_pkg::COUNT_BITS-1:0] pulses_b,
   output logic [ept_pkg::SPEED_BITS-1:0] speed
);

   logic [ept_pkg::COUNT_BITS-1:0] larger;
   logic [ept_pkg::X_BITS-1:0]     scaled;
   logic [ept_pkg::PROD_BITS-1:0]  product;
   logic [ept_pkg::COUNT_BITS-1:0] quotient;

   // Division by the reduced pulse count uses a rounded-up reciprocal that is
   // exact over the whole range of the scaled count.
   always_comb begin
      larger   = (pulses_a > pulses_b) ? pulses_a : pulses_b;
      scaled   = ept_pkg::X_BITS'(larger) * ept_pkg::X_BITS'(ept_pkg::SCALE_NUM);
      product  = ept_pkg::PROD_BITS'(scaled) * ept_pkg::PROD_BITS'(ept_pkg::RECIP);
      quotient = product[ept_pkg::RECIP_SHIFT +: ept_pkg::COUNT_BITS];
      if (ept_pkg::SAT_BITS'(quotient) > ept_pkg::SAT_BITS'(ept_pkg::SPEED_MAX)) begin
         speed = ept_pkg::SPEED_MAX;
      end else begin
         speed = ept_pkg::SPEED_BITS'(quotient);
      end
   end

endmodule

>>> hdl/ept_core.sv
// Tachometer state: pulse counters, window divider, position, direction, watchdog.
`include "assert_macros.svh"

module ept_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             fire,
   input  ept_pkg::command_type             command,
   input  logic [ept_pkg::DIR_BITS-1:0]     direction_value,
   input  logic [ept_pkg::WINDOW_BITS-1:0]  window_ticks_minus_one,
   output logic                             produces,
   output ept_pkg::result_type              result
);

   logic [ept_pkg::WINDOW_BITS-1:0]   divider_ff,  divider_in;
   logic [ept_pkg::COUNT_BITS-1:0]    pulses_a_ff, pulses_a_in;
   logic [ept_pkg::COUNT_BITS-1:0]    pulses_b_ff, pulses_b_in;
   logic [ept_pkg::POSITION_BITS-1:0] position_ff, position_in;
   ept_pkg::direction_type            direction_ff, direction_in;
   logic                              watchdog_ff, watchdog_in;

   logic [ept_pkg::SPEED_BITS-1:0]    speed;
   logic [ept_pkg::POSITION_BITS-1:0] position_next;
   ept_pkg::direction_type            direction_after;
   ept_pkg::direction_type            direction_set;

   ept_speed u_speed (
      .pulses_a (pulses_a_ff),
      .pulses_b (pulses_b_ff),
      .speed    (speed)
   );

   assign produces = (command == ept_pkg::CMD_TICK) &&
                     (divider_ff >= window_ticks_minus_one);

   always_comb begin
      unique case (direction_ff)
         ept_pkg::DIR_RIGHT:
            position_next = position_ff + ept_pkg::POSITION_BITS'(speed);
         ept_pkg::DIR_LEFT:
            position_next = position_ff - ept_pkg::POSITION_BITS'(speed);
         default:
            position_next = position_ff;
      endcase
      direction_after = (speed == '0) ? ept_pkg::DIR_UNDEF : direction_ff;
      unique case (direction_value)
         ept_pkg::DIR_RIGHT: direction_set = ept_pkg::DIR_RIGHT;
         ept_pkg::DIR_LEFT:  direction_set = ept_pkg::DIR_LEFT;
         default:            direction_set = ept_pkg::DIR_UNDEF;
      endcase
   end

   always_comb begin
      divider_in   = divider_ff;
      pulses_a_in  = pulses_a_ff;
      pulses_b_in  = pulses_b_ff;
      position_in  = position_ff;
      direction_in = direction_ff;
      watchdog_in  = watchdog_ff;
      if (fire) begin
         unique case (command)
            ept_pkg::CMD_PULSE_A: begin
               if (pulses_a_ff != '1) begin
                  pulses_a_in = pulses_a_ff + 1'b1;
               end
            end
            ept_pkg::CMD_PULSE_B: begin
               if (pulses_b_ff != '1) begin
                  pulses_b_in = pulses_b_ff + 1'b1;
               end
            end
            ept_pkg::CMD_SET_DIR: begin
               direction_in = direction_set;
            end
            ept_pkg::CMD_TICK: begin
               if (produces) begin
                  divider_in   = '0;
                  pulses_a_in  = '0;
                  pulses_b_in  = '0;
                  position_in  = position_next;
                  direction_in = direction_after;
                  watchdog_in  = ~watchdog_ff;
               end else begin
                  divider_in = divider_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divider_ff   <= '0;
         pulses_a_ff  <= '0;
         pulses_b_ff  <= '0;
         position_ff  <= '0;
         direction_ff <= ept_pkg::DIR_UNDEF;
         watchdog_ff  <= 1'b0;
      end else begin
         divider_ff   <= divider_in;
         pulses_a_ff  <= pulses_a_in;
         pulses_b_ff  <= pulses_b_in;
         position_ff  <= position_in;
         direction_ff <= direction_in;
         watchdog_ff  <= watchdog_in;
      end
   end

   assign result.position_tenths = position_next[ept_pkg::POS_OUT_BITS-1:0];
   assign result.speed_tenths    = speed;
   assign result.direction_now   = direction_after;
   assign result.watchdog_level  = ~watchdog_ff;

   `ASSERT_CLOCKED(a_close_clears, clock, reset, fire && produces |=> divider_ff == '0 && pulses_a_ff == '0 && pulses_b_ff == '0, "window close did not clear the counters")
   `ASSERT_CLOCKED(a_close_toggles, clock, reset, fire && produces |=> watchdog_ff != $past(watchdog_ff), "watchdog did not toggle at window close")
   `ASSERT_CLOCKED(a_position_hold, clock, reset, !(fire && produces) |=> $stable(position_ff), "position moved without a window close")

endmodule

>>> hdl/encoder_pulse_tachometer.sv
// Top level of the encoder pulse tachometer: input register, state core and result register.
//
// The block takes one event transaction per clock cycle: a pulse on channel A or B, a timer
// tick, or a new direction. Every event is held in the input register, where it is
// applied to the counters and position; a tick that closes the window loads the result
// register, so its reading reaches the result channel by way of the input register and
// then the result register. The rate of one event per cycle holds for as long as results
// are taken; a held result stalls only a following window close, which waits in the input
// register while further events back up behind it. The window length register is written
// over the configuration port and should be changed only while no event is in flight.
module encoder_pulse_tachometer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // direction_value [1:0], zero padding above
   input  logic [ept_pkg::REQ_TDATA_BITS-1:0]  req_tdata,
   // command [1:0]
   input  logic [ept_pkg::REQ_TUSER_BITS-1:0]  req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // position_tenths [31:0], speed_tenths [47:32], direction_now [49:48],
   // watchdog_level [50], zero padding above
   output logic [ept_pkg::RSP_TDATA_BITS-1:0]  rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ept_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [ept_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [ept_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);

   logic [ept_pkg::WINDOW_BITS-1:0] window_ticks_minus_one;

   logic                            in_valid_ff, in_valid_in;
   ept_pkg::command_type            command_ff, command_in;
   logic [ept_pkg::DIR_BITS-1:0]    dval_ff, dval_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   ept_pkg::result_type             rsp_data_ff, rsp_data_in;

   logic                            produces;
   logic                            out_free;
   logic                            advance;
   ept_pkg::result_type             result;

   ept_csr u_csr (
      .clock                  (clock),
      .reset                  (reset),
      .csr_psel               (csr_psel),
      .csr_penable            (csr_penable),
      .csr_pwrite             (csr_pwrite),
      .csr_paddr              (csr_paddr),
      .csr_pwdata             (csr_pwdata),
      .csr_prdata             (csr_prdata),
      .csr_pready             (csr_pready),
      .window_ticks_minus_one (window_ticks_minus_one)
   );

   ept_core u_core (
      .clock                  (clock),
      .reset                  (reset),
      .fire                   (advance),
      .command                (command_ff),
      .direction_value        (dval_ff),
      .window_ticks_minus_one (window_ticks_minus_one),
      .produces               (produces),
      .result                 (result)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!produces || out_free);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      command_in  = command_ff;
      dval_in     = dval_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         command_in  = ept_pkg::command_type'(req_tuser[1:0]);
         dval_in     = req_tdata[ept_pkg::DIR_BITS-1:0];
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance && produces) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      command_ff  <= command_in;
      dval_ff     <= dval_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = ept_pkg::RSP_TDATA_BITS'({rsp_data_ff.watchdog_level,
                                                 rsp_data_ff.direction_now,
                                                 rsp_data_ff.speed_tenths,
                                                 rsp_data_ff.position_tenths});

endmodule
